// ----- hw/rtl/demand_page_translate_alloc_assert.svh -----
// Assertion macros for the demand page translate block.
// Used by the top level; needs clk and rst in scope.
`ifndef DEMAND_PAGE_TRANSLATE_ALLOC_ASSERT_SVH
`define DEMAND_PAGE_TRANSLATE_ALLOC_ASSERT_SVH

// Same-cycle implication.
`define DPTA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DPTA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/dpta_pkg.sv -----
// Shared types and constants for the demand page translate block.
// No dependencies.
package dpta_pkg;

  localparam int unsigned HEAP_PAGES_DEF  = 16;
  localparam int unsigned FRAME_COUNT_DEF = 1024;

  localparam int unsigned VA_W       = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned INDEX_W    = VA_W - PAGE_SHIFT;
  localparam int unsigned FRAME_W    = 10;
  localparam int unsigned PADDR_W    = FRAME_W + PAGE_SHIFT;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [VA_W-1:0] KERNEL_BASE = 32'hC000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT         = 3'd0,
    ST_ALLOC       = 3'd1,
    ST_BELOW_BASE  = 3'd2,
    ST_BEYOND_HEAP = 3'd3,
    ST_NO_FRAME    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_LOOK,
    T_ALLOC,
    T_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    A_CLEAR,
    A_IDLE,
    A_CHECK,
    A_FAIL
  } alloc_state_t;

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] base;
  } alloc_ctrl_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic               found;
    logic [FRAME_W-1:0] frame;
  } alloc_stat_t;

endpackage

// ----- hw/rtl/dpta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpta_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/dpta_alloc.sv -----
// Frame allocator: frame-use bitmap in RAM, clearing pass after reset,
// and a one-frame-per-cycle upward scan. Uses dpta_pkg and dpta_ram.
module dpta_alloc #(
  parameter int unsigned FRAME_COUNT = dpta_pkg::FRAME_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dpta_pkg::alloc_ctrl_t ctrl,
  output dpta_pkg::alloc_stat_t stat
);

  localparam int unsigned AW     = $clog2(FRAME_COUNT);
  localparam int unsigned FIDX_W = $clog2(FRAME_COUNT + 1);

  dpta_pkg::alloc_state_t state, state_next;
  logic [FIDX_W-1:0] idx, idx_next, idx_inc;
  logic [AW-1:0]     clr, clr_next;
  logic [FIDX_W+dpta_pkg::FRAME_W-1:0] idx_ext;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  assign idx_inc = idx + 1'b1;
  assign idx_ext = {{dpta_pkg::FRAME_W{1'b0}}, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpta_pkg::A_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    idx <= idx_next;
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    clr_next   = clr;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    ram_wdata  = 1'b1;
    stat.idle  = 1'b0;
    stat.done  = 1'b0;
    stat.found = 1'b0;
    stat.frame = idx_ext[dpta_pkg::FRAME_W-1:0];
    unique case (state)
      dpta_pkg::A_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = 1'b0;
        clr_next  = clr + 1'b1;
        if (clr == AW'(FRAME_COUNT - 1)) begin
          state_next = dpta_pkg::A_IDLE;
        end
      end
      dpta_pkg::A_IDLE: begin
        stat.idle = 1'b1;
        if (ctrl.start) begin
          if (32'(ctrl.base) < 32'(FRAME_COUNT)) begin
            idx_next   = FIDX_W'(ctrl.base);
            state_next = dpta_pkg::A_CHECK;
          end else begin
            state_next = dpta_pkg::A_FAIL;
          end
        end
      end
      dpta_pkg::A_CHECK: begin
        if (!ram_rdata) begin
          ram_we     = 1'b1;
          stat.done  = 1'b1;
          stat.found = 1'b1;
          state_next = dpta_pkg::A_IDLE;
        end else if (idx_inc == FIDX_W'(FRAME_COUNT)) begin
          stat.done  = 1'b1;
          state_next = dpta_pkg::A_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end
      dpta_pkg::A_FAIL: begin
        stat.done  = 1'b1;
        state_next = dpta_pkg::A_IDLE;
      end
      default: begin
        state_next = dpta_pkg::A_IDLE;
      end
    endcase
  end

  dpta_ram #(
    .WIDTH (1),
    .DEPTH (FRAME_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_next[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

// ----- hw/rtl/demand_page_translate_alloc.sv -----
// An accepted item goes straight to the output stage when out of range, through a page
// table lookup for a hit, and through the lookup and a bitmap scan for an allocation or
// a failed scan; the scan reads frames from reserved_frames upward, one a cycle.
// One item at a time: s_tready rises with m_tvalid.
// After reset a clearing pass zeroes the frame bitmap and the page table; s_tready
// stays low until both are cleared.
module demand_page_translate_alloc #(
  parameter int unsigned HEAP_PAGES  = dpta_pkg::HEAP_PAGES_DEF,
  parameter int unsigned FRAME_COUNT = dpta_pkg::FRAME_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,   // reserved_frames
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // [31:0] virtual_address
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,     // [21:0] physical_address, [23:22] zero
  output logic [2:0]  m_tuser      // [2:0] status
);

  localparam int unsigned PW    = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
  localparam int unsigned PT_W  = dpta_pkg::FRAME_W + 1;
  localparam int unsigned OFF_W = dpta_pkg::PAGE_SHIFT;

  dpta_pkg::top_state_t  state, state_next;
  dpta_pkg::alloc_ctrl_t alloc_ctrl;
  dpta_pkg::alloc_stat_t alloc_st;
  dpta_pkg::status_t     res_st, res_st_next;

  logic [dpta_pkg::CFG_W-1:0]   reserved_frames;
  logic [PW-1:0]                page_idx;
  logic [OFF_W-1:0]             offset;
  logic [dpta_pkg::PADDR_W-1:0] res_pa, res_pa_next;
  logic [PW-1:0]                pt_clr;
  logic                         pt_cleared;
  logic [dpta_pkg::VA_W-1:0]    rel;
  logic                         below, beyond, accept, out_free, load_idx;
  logic                         pt_we;
  logic [PW-1:0]                pt_waddr;
  logic [PT_W-1:0]              pt_wdata, pt_rdata;

  assign rel      = s_tdata - dpta_pkg::KERNEL_BASE;
  assign below    = s_tdata < dpta_pkg::KERNEL_BASE;
  assign beyond   = rel[dpta_pkg::VA_W-1:dpta_pkg::PAGE_SHIFT]
                    >= dpta_pkg::INDEX_W'(HEAP_PAGES);
  assign s_tready = (state == dpta_pkg::T_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= dpta_pkg::T_CLEAR;
      reserved_frames <= '0;
      pt_clr          <= '0;
      pt_cleared      <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        reserved_frames <= cfg_wdata;
      end
      if (state == dpta_pkg::T_CLEAR && !pt_cleared) begin
        pt_clr <= pt_clr + 1'b1;
        if (pt_clr == PW'(HEAP_PAGES - 1)) begin
          pt_cleared <= 1'b1;
        end
      end
      if (state == dpta_pkg::T_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (load_idx) begin
      page_idx <= rel[dpta_pkg::PAGE_SHIFT +: PW];
      offset   <= rel[OFF_W-1:0];
    end
    res_pa <= res_pa_next;
    res_st <= res_st_next;
    if (state == dpta_pkg::T_OUT && out_free) begin
      m_tdata <= {2'b00, res_pa};
      m_tuser <= res_st;
    end
  end

  always_comb begin
    state_next       = state;
    res_pa_next      = res_pa;
    res_st_next      = res_st;
    load_idx         = 1'b0;
    alloc_ctrl.start = 1'b0;
    alloc_ctrl.base  = reserved_frames;
    pt_we            = 1'b0;
    pt_waddr         = page_idx;
    pt_wdata         = {1'b1, alloc_st.frame};
    unique case (state)
      dpta_pkg::T_CLEAR: begin
        pt_we    = !pt_cleared;
        pt_waddr = pt_clr;
        pt_wdata = '0;
        if (pt_cleared && alloc_st.idle) begin
          state_next = dpta_pkg::T_IDLE;
        end
      end
      dpta_pkg::T_IDLE: begin
        if (accept) begin
          res_pa_next = '0;
          priority if (below) begin
            res_st_next = dpta_pkg::ST_BELOW_BASE;
            state_next  = dpta_pkg::T_OUT;
          end else if (beyond) begin
            res_st_next = dpta_pkg::ST_BEYOND_HEAP;
            state_next  = dpta_pkg::T_OUT;
          end else begin
            load_idx   = 1'b1;
            state_next = dpta_pkg::T_LOOK;
          end
        end
      end
      dpta_pkg::T_LOOK: begin
        if (pt_rdata[PT_W-1]) begin
          res_pa_next = {pt_rdata[dpta_pkg::FRAME_W-1:0], offset};
          res_st_next = dpta_pkg::ST_HIT;
          state_next  = dpta_pkg::T_OUT;
        end else begin
          alloc_ctrl.start = 1'b1;
          state_next       = dpta_pkg::T_ALLOC;
        end
      end
      dpta_pkg::T_ALLOC: begin
        if (alloc_st.done) begin
          if (alloc_st.found) begin
            pt_we       = 1'b1;
            res_pa_next = {alloc_st.frame, offset};
            res_st_next = dpta_pkg::ST_ALLOC;
          end else begin
            res_pa_next = '0;
            res_st_next = dpta_pkg::ST_NO_FRAME;
          end
          state_next = dpta_pkg::T_OUT;
        end
      end
      dpta_pkg::T_OUT: begin
        if (out_free) begin
          state_next = dpta_pkg::T_IDLE;
        end
      end
      default: begin
        state_next = dpta_pkg::T_IDLE;
      end
    endcase
  end

  dpta_ram #(
    .WIDTH (PT_W),
    .DEPTH (HEAP_PAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (rel[dpta_pkg::PAGE_SHIFT +: PW]),
    .rdata (pt_rdata)
  );

  dpta_alloc #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_alloc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (alloc_ctrl),
    .stat (alloc_st)
  );

`include "demand_page_translate_alloc_assert.svh"

  `DPTA_ASSERT_IMPL(a_done_in_alloc, alloc_st.done, state == dpta_pkg::T_ALLOC)
  `DPTA_ASSERT_IMPL(a_start_idle, alloc_ctrl.start, alloc_st.idle)
  `DPTA_ASSERT_IMPL(a_pt_fill_src, pt_we && state != dpta_pkg::T_CLEAR, alloc_st.found)
  `DPTA_ASSERT_NEXT(a_out_load, state == dpta_pkg::T_OUT && out_free, m_tvalid && s_tready)

endmodule
